// File: rtl/rbsf_pkg.sv
// Package: payload structs, config index codes and shared helpers for the spring force block.
package rbsf_pkg;

	localparam int unsigned COMP_W = 16;
	localparam int unsigned VEC_W  = 3 * COMP_W;

	typedef enum logic [1:0] {
		CFG_STIFFNESS  = 2'd0,
		CFG_DAMPING    = 2'd1,
		CFG_FIRST_OFF  = 2'd2,
		CFG_SECOND_OFF = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic              which_end;
		logic [VEC_W-1:0]  body_position;
		logic [63:0]       body_orientation;
		logic [15:0]       body_scale;
		logic [VEC_W-1:0]  body_velocity;
		logic [VEC_W-1:0]  body_angular_velocity;
		logic [VEC_W-1:0]  other_position;
	} in_t;

	typedef struct packed {
		logic [VEC_W-1:0] force_delta;
		logic [VEC_W-1:0] torque_delta;
		logic             saturated;
	} out_t;

	typedef struct packed {
		logic [15:0]      stiffness;
		logic [15:0]      damping;
		logic [VEC_W-1:0] first_off;
		logic [VEC_W-1:0] second_off;
	} cfg_t;

	// Pull one signed component out of a packed vector.
	function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] v,
		input int unsigned i);
		return $signed(v[i*COMP_W +: COMP_W]);
	endfunction

	// Cyclic successor indices for cross products.
	function automatic int unsigned nx1(input int unsigned i);
		case (i)
			0:       return 1;
			1:       return 2;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned nx2(input int unsigned i);
		case (i)
			0:       return 2;
			1:       return 0;
			default: return 1;
		endcase
	endfunction

	// Clip to the component range; bit COMP_W is the clip flag.
	function automatic logic [COMP_W:0] sat_c(input logic signed [62:0] v);
		logic signed [62:0] hi;
		logic signed [62:0] lo;
		hi = 63'sd32767;
		lo = -63'sd32768;
		if (v > hi) return {1'b1, 16'h7fff};
		else if (v < lo) return {1'b1, 16'h8000};
		else return {1'b0, v[COMP_W-1:0]};
	endfunction

endpackage

// File: rtl/rigid_body_spring_force.sv
// Top level: eight-stage pipeline computing damped spring force and torque increments.
//
//   channel | signals                          | direction
//   in      | in_valid, in_ready, in_data      | body item into the pipeline
//   out     | out_valid, out_ready, out_data   | force/torque result out
//   cfg     | cfg_valid, cfg_ready, cfg_index, | register writes, always ready
//           | cfg_data                         |
//
// Accepts one item per cycle while the output stage is empty or being taken.
// Stages: quaternion products, matrix times offset, row sum and scale, lever and
// angular cross, spring and damper products, force clip, torque products, torque clip.
// All stages advance together whenever the output stage is empty or being taken.
// Reset clears the stage valid bits and the configuration registers.
module rigid_body_spring_force (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rbsf_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rbsf_pkg::out_t              out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [rbsf_pkg::VEC_W-1:0]  cfg_data
);

	rbsf_pkg::cfg_t regs;

	rbsf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	assign en       = !v_s8 || out_ready;
	assign in_ready = en;

	// Valid bits advance with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Stage 1: quaternion products, offset select, capture vectors.
	logic signed [31:0] p_xx_s1, p_yy_s1, p_zz_s1, p_xy_s1, p_wz_s1;
	logic signed [31:0] p_xz_s1, p_wy_s1, p_yz_s1, p_wx_s1;
	logic signed [15:0] o_s1 [3];
	logic signed [15:0] pos_s1 [3], vel_s1 [3], w_s1 [3], oth_s1 [3];
	logic [15:0]        sc_s1;
	logic signed [15:0] qw, qx, qy, qz;
	logic [rbsf_pkg::VEC_W-1:0] off_sel;

	assign qw      = $signed(in_data.body_orientation[63:48]);
	assign qx      = $signed(in_data.body_orientation[47:32]);
	assign qy      = $signed(in_data.body_orientation[31:16]);
	assign qz      = $signed(in_data.body_orientation[15:0]);
	assign off_sel = in_data.which_end ? regs.second_off : regs.first_off;

	always_ff @(posedge clk) begin
		if (en) begin
			p_xx_s1 <= qx * qx;
			p_yy_s1 <= qy * qy;
			p_zz_s1 <= qz * qz;
			p_xy_s1 <= qx * qy;
			p_wz_s1 <= qw * qz;
			p_xz_s1 <= qx * qz;
			p_wy_s1 <= qw * qy;
			p_yz_s1 <= qy * qz;
			p_wx_s1 <= qw * qx;
			sc_s1   <= in_data.body_scale;
			for (int i = 0; i < 3; i++) begin
				o_s1[i]   <= rbsf_pkg::comp(off_sel, i);
				pos_s1[i] <= rbsf_pkg::comp(in_data.body_position, i);
				vel_s1[i] <= rbsf_pkg::comp(in_data.body_velocity, i);
				w_s1[i]   <= rbsf_pkg::comp(in_data.body_angular_velocity, i);
				oth_s1[i] <= rbsf_pkg::comp(in_data.other_position, i);
			end
		end
	end

	// Stage 2: build rotation matrix (Q.28) and multiply by the offset.
	logic signed [33:0] m [3][3];
	logic signed [33:0] one28;
	logic signed [49:0] mo_s2 [3][3];
	logic signed [15:0] pos_s2 [3], vel_s2 [3], w_s2 [3], oth_s2 [3];
	logic [15:0]        sc_s2;

	assign one28 = 34'sh1000_0000;

	always_comb begin
		m[0][0] = one28 - ((34'(p_yy_s1) + 34'(p_zz_s1)) <<< 1);
		m[0][1] = (34'(p_xy_s1) - 34'(p_wz_s1)) <<< 1;
		m[0][2] = (34'(p_xz_s1) + 34'(p_wy_s1)) <<< 1;
		m[1][0] = (34'(p_xy_s1) + 34'(p_wz_s1)) <<< 1;
		m[1][1] = one28 - ((34'(p_xx_s1) + 34'(p_zz_s1)) <<< 1);
		m[1][2] = (34'(p_yz_s1) - 34'(p_wx_s1)) <<< 1;
		m[2][0] = (34'(p_xz_s1) - 34'(p_wy_s1)) <<< 1;
		m[2][1] = (34'(p_yz_s1) + 34'(p_wx_s1)) <<< 1;
		m[2][2] = one28 - ((34'(p_xx_s1) + 34'(p_yy_s1)) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s2 <= sc_s1;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mo_s2[i][j] <= m[i][j] * o_s1[j];
				end
				pos_s2[i] <= pos_s1[i];
				vel_s2[i] <= vel_s1[i];
				w_s2[i]   <= w_s1[i];
				oth_s2[i] <= oth_s1[i];
			end
		end
	end

	// Stage 3: row sum, round to Q.8, multiply by scale.
	logic signed [51:0] row_sum [3];
	logic signed [23:0] r [3];
	logic signed [16:0] sc_ext;
	logic signed [40:0] rs_s3 [3];
	logic signed [15:0] pos_s3 [3], vel_s3 [3], w_s3 [3], oth_s3 [3];

	assign sc_ext = $signed({1'b0, sc_s2});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_sum[i] = 52'(mo_s2[i][0]) + 52'(mo_s2[i][1]) + 52'(mo_s2[i][2])
				+ 52'sh800_0000;
			r[i] = row_sum[i][51:28];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rs_s3[i]  <= r[i] * sc_ext;
				pos_s3[i] <= pos_s2[i];
				vel_s3[i] <= vel_s2[i];
				w_s3[i]   <= w_s2[i];
				oth_s3[i] <= oth_s2[i];
			end
		end
	end

	// Stage 4: lever a, stretch x, angular cross product terms.
	logic signed [40:0] rs_rnd [3];
	logic signed [32:0] a4 [3];
	logic signed [32:0] a_s4 [3];
	logic signed [34:0] x_s4 [3];
	logic signed [48:0] cp_s4 [3], cn_s4 [3];
	logic signed [15:0] vel_s4 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rs_rnd[i] = rs_s3[i] + 41'sd128;
			a4[i]     = rs_rnd[i][40:8];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s4[i]   <= a4[i];
				x_s4[i]   <= 35'(pos_s3[i]) + 35'(a4[i]) - 35'(oth_s3[i]);
				cp_s4[i]  <= w_s3[rbsf_pkg::nx1(i)] * a4[rbsf_pkg::nx2(i)];
				cn_s4[i]  <= w_s3[rbsf_pkg::nx2(i)] * a4[rbsf_pkg::nx1(i)];
				vel_s4[i] <= vel_s3[i];
			end
		end
	end

	// Stage 5: point velocity, spring and damper products.
	logic signed [49:0] wa_rnd [3];
	logic signed [42:0] vp [3];
	logic signed [16:0] k_ext, b_ext;
	logic signed [51:0] kx_s5 [3];
	logic signed [59:0] bv_s5 [3];
	logic signed [32:0] a_s5 [3];

	assign k_ext = $signed({1'b0, regs.stiffness});
	assign b_ext = $signed({1'b0, regs.damping});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wa_rnd[i] = 50'(cp_s4[i]) - 50'(cn_s4[i]) + 50'sd128;
			vp[i]     = 43'(vel_s4[i]) + 43'($signed(wa_rnd[i][49:8]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				kx_s5[i] <= k_ext * x_s4[i];
				bv_s5[i] <= b_ext * vp[i];
				a_s5[i]  <= a_s4[i];
			end
		end
	end

	// Stage 6: negate, halve with rounding, clip the force.
	logic signed [61:0] fneg [3];
	logic [16:0]        fsat [3];
	logic signed [15:0] f_s6 [3];
	logic               flag_s6;
	logic signed [32:0] a_s6 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fneg[i] = 62'sd256 - 62'(kx_s5[i]) - 62'(bv_s5[i]);
			fsat[i] = rbsf_pkg::sat_c(63'($signed(fneg[i][61:9])));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s6 <= fsat[0][16] | fsat[1][16] | fsat[2][16];
			for (int i = 0; i < 3; i++) begin
				f_s6[i] <= $signed(fsat[i][15:0]);
				a_s6[i] <= a_s5[i];
			end
		end
	end

	// Stage 7: torque cross product terms.
	logic signed [48:0] tp_s7 [3], tn_s7 [3];
	logic signed [15:0] f_s7 [3];
	logic               flag_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s7 <= flag_s6;
			for (int i = 0; i < 3; i++) begin
				tp_s7[i] <= a_s6[rbsf_pkg::nx1(i)] * f_s6[rbsf_pkg::nx2(i)];
				tn_s7[i] <= a_s6[rbsf_pkg::nx2(i)] * f_s6[rbsf_pkg::nx1(i)];
				f_s7[i]  <= f_s6[i];
			end
		end
	end

	// Stage 8: round and clip the torque, pack the result.
	logic signed [49:0] t_rnd [3];
	logic [16:0]        tsat [3];
	rbsf_pkg::out_t     res_s8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_rnd[i] = 50'(tp_s7[i]) - 50'(tn_s7[i]) + 50'sd128;
			tsat[i]  = rbsf_pkg::sat_c(63'($signed(t_rnd[i][49:8])));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s8.saturated <= flag_s7 | tsat[0][16] | tsat[1][16] | tsat[2][16];
			for (int i = 0; i < 3; i++) begin
				res_s8.force_delta[i*rbsf_pkg::COMP_W +: rbsf_pkg::COMP_W]  <= f_s7[i];
				res_s8.torque_delta[i*rbsf_pkg::COMP_W +: rbsf_pkg::COMP_W] <=
					tsat[i][15:0];
			end
		end
	end

	assign out_valid = v_s8;
	assign out_data  = res_s8;

	// Hold the valid bits of stages 1 to 7 while the output waits.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7}))
		else $error("pipeline moved during stall");

	// Take an input transfer into stage 1.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted item lost at entry");

	// An item in stage 7 reaches the output stage whenever the pipeline advances.
	a_out_take: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && en) |=> out_valid)
		else $error("item lost before output");

endmodule

// File: rtl/rbsf_cfg.sv
// Configuration register file: stiffness, damping and the two attach offsets.
module rbsf_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [rbsf_pkg::VEC_W-1:0] cfg_data,
	output rbsf_pkg::cfg_t       regs
);

	rbsf_pkg::cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Write the addressed register on a transfer; drop unknown indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg_valid) begin
			case (rbsf_pkg::cfg_idx_t'(cfg_index))
				rbsf_pkg::CFG_STIFFNESS:  regs_q.stiffness  <= cfg_data[15:0];
				rbsf_pkg::CFG_DAMPING:    regs_q.damping    <= cfg_data[15:0];
				rbsf_pkg::CFG_FIRST_OFF:  regs_q.first_off  <= cfg_data;
				rbsf_pkg::CFG_SECOND_OFF: regs_q.second_off <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
